// File: rtl/gcvv_pkg.sv
package gcvv_pkg;

   localparam int REPLICAS   = 16;
   localparam int COUNT_BITS = 32;
   localparam int ADDR_BITS  = $clog2(REPLICAS);
   localparam int TOTAL_BITS = 36;
   localparam int POS_BITS   = 5;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [1:0] OP_INCREMENT = 2'd0;
   localparam logic [1:0] OP_SUMMARY   = 2'd1;
   localparam logic [1:0] OP_UPDATE    = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
   localparam logic [1:0] ERR_SUMMARY   = 2'd2;
   localparam logic [1:0] ERR_SATURATED = 2'd3;

   localparam logic CSR_LOCAL_INDEX     = 1'b0;
   localparam logic CSR_ACTIVE_REPLICAS = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  index;
      logic [31:0] value;
      logic        last;
   } req_type;

   typedef struct packed {
      logic                  update_valid;
      logic [3:0]            update_index;
      logic [31:0]           update_value;
      logic                  summary_done;
      logic [1:0]            relation;
      logic [4:0]            update_count;
      logic                  changed;
      logic [TOTAL_BITS-1:0] total;
      logic [1:0]            error;
   } rsp_type;

endpackage

// File: rtl/gcvv_store.sv
module gcvv_store
   import gcvv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [COUNT_BITS-1:0] rd_data,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [COUNT_BITS-1:0] wr_data
);

   logic [COUNT_BITS-1:0] count_mem [REPLICAS];
   logic [REPLICAS-1:0]   entry_valid_ff;
   logic [COUNT_BITS-1:0] rd_word_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= count_mem[rd_addr];
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= entry_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// File: rtl/gcounter_version_vector_merge.sv
// Grow-only counter version vector: one count per replica in a 16-entry
// synchronous RAM, a running total, and streaming summary compare. For each
// item, the entry is read in the cycle the item is accepted, then the
// result is computed, the entry written back and the result loaded into
// the output register once that register is free. A new item is taken
// only after the previous item's result has been loaded; the block takes
// no new item while one is in flight. Reset is synchronous; configuration
// writes are always accepted.
module gcounter_version_vector_merge
   import gcvv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata
);

   logic [3:0]            local_index_ff;
   logic [4:0]            active_replicas_ff;
   logic [4:0]            active;

   logic                  busy_ff;
   req_type               item_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  seen_local_ff, seen_local_in;
   logic                  seen_remote_ff, seen_remote_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [4:0]            pend_ff, pend_in;
   logic                  fault_ff, fault_in;

   logic                  accept;
   logic                  finish;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [COUNT_BITS-1:0] old_count;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS:0]   inc_sum;
   logic [COUNT_BITS-1:0] remote;
   logic                  fault_now;
   rsp_type               rsp_in;

   assign csr_ready = 1'b1;
   assign active    = (active_replicas_ff < 5'(REPLICAS)) ? active_replicas_ff : 5'(REPLICAS);

   always_ff @(posedge clock) begin
      if (reset) begin
         local_index_ff     <= '0;
         active_replicas_ff <= 5'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOCAL_INDEX:     local_index_ff     <= csr_wdata[3:0];
            CSR_ACTIVE_REPLICAS: active_replicas_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign finish    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign rd_addr   = (req_data.operation == OP_INCREMENT) ?
                      local_index_ff[ADDR_BITS-1:0] : req_data.index[ADDR_BITS-1:0];

   gcvv_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (old_count),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign inc_sum = {1'b0, old_count} + {1'b0, item_ff.value[COUNT_BITS-1:0]};
   assign remote  = (item_ff.value > 32'(COUNT_MAX)) ? COUNT_MAX :
                    item_ff.value[COUNT_BITS-1:0];
   assign fault_now = fault_ff || (POS_BITS'(item_ff.index) != pos_ff) ||
                      (5'(item_ff.index) >= active);

   always_comb begin
      rsp_in         = '0;
      wr_en          = 1'b0;
      wr_addr        = item_ff.index[ADDR_BITS-1:0];
      wr_data        = remote;
      total_in       = total_ff;
      seen_local_in  = seen_local_ff;
      seen_remote_in = seen_remote_ff;
      pos_in         = pos_ff;
      pend_in        = pend_ff;
      fault_in       = fault_ff;
      case (item_ff.operation)
         OP_INCREMENT: begin
            if (5'(local_index_ff) >= active) begin
               rsp_in.error = ERR_UNKNOWN;
            end else begin
               wr_en   = 1'b1;
               wr_addr = local_index_ff[ADDR_BITS-1:0];
               if (inc_sum[COUNT_BITS] || (inc_sum[COUNT_BITS-1:0] > COUNT_MAX)) begin
                  wr_data      = COUNT_MAX;
                  rsp_in.error = ERR_SATURATED;
               end else begin
                  wr_data = inc_sum[COUNT_BITS-1:0];
               end
               total_in = total_ff + TOTAL_BITS'(wr_data) - TOTAL_BITS'(old_count);
            end
         end
         OP_SUMMARY: begin
            fault_in = fault_now;
            if (fault_now) begin
               rsp_in.error = ERR_SUMMARY;
            end else begin
               if (old_count > remote) begin
                  seen_local_in       = 1'b1;
                  rsp_in.update_valid = 1'b1;
                  rsp_in.update_index = item_ff.index;
                  rsp_in.update_value = 32'(old_count);
                  pend_in             = pend_ff + 5'd1;
               end else if (old_count < remote) begin
                  seen_remote_in = 1'b1;
               end
               pos_in = pos_ff + POS_BITS'(1);
            end
            if (item_ff.last) begin
               rsp_in.summary_done = 1'b1;
               if (fault_now || (pos_in != POS_BITS'(active))) begin
                  rsp_in.error = ERR_SUMMARY;
               end else begin
                  rsp_in.relation     = {seen_remote_in, seen_local_in};
                  rsp_in.update_count = pend_in;
               end
               seen_local_in  = 1'b0;
               seen_remote_in = 1'b0;
               pos_in         = '0;
               pend_in        = '0;
               fault_in       = 1'b0;
            end
         end
         OP_UPDATE: begin
            if (5'(item_ff.index) >= active) begin
               rsp_in.error = ERR_UNKNOWN;
            end else if (remote > old_count) begin
               wr_en          = 1'b1;
               total_in       = total_ff + TOTAL_BITS'(remote) - TOTAL_BITS'(old_count);
               rsp_in.changed = 1'b1;
            end
         end
         default: ;
      endcase
      rsp_in.total = total_in;
      if (!finish) begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         total_ff       <= '0;
         seen_local_ff  <= 1'b0;
         seen_remote_ff <= 1'b0;
         pos_ff         <= '0;
         pend_ff        <= '0;
         fault_ff       <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (finish) begin
            total_ff       <= total_in;
            seen_local_ff  <= seen_local_in;
            seen_remote_ff <= seen_remote_in;
            pos_ff         <= pos_in;
            pend_ff        <= pend_in;
            fault_ff       <= fault_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_BITS'(REPLICAS))
      else $error("summary position beyond replica count");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 5'(pos_ff))
      else $error("pending update count exceeds compared elements");

   a_changed_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.changed |-> rsp_ff.error == ERR_NONE && !rsp_ff.summary_done)
      else $error("changed item carries error or summary status");

   // a last element may still carry an update entry when the summary length is wrong
   a_update_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.update_valid && !rsp_ff.summary_done |->
         rsp_ff.error == ERR_NONE)
      else $error("update entry emitted with error");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> busy_ff && !req_ready)
      else $error("item accepted without entering compute cycle");
`endif

endmodule
